// ===== rtl/sorted_array_insert_search_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key array
// Shared concurrent check forms, clocked with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_INSERT_SEARCH_DEFINES_SVH
`define SORTED_ARRAY_INSERT_SEARCH_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SSI_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define SSI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define SSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg
// Types, constants and microprogram for the sorted key array.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_WIDTH = 32;
	localparam int AW        = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = 8;
	localparam int PC_W      = 4;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_FIND   = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]                  action;
		logic signed [KEY_WIDTH-1:0] key;
		logic [IDX_W-1:0]            index;
	} request_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [CNT_W-1:0]            position;
		logic                        found;
		logic signed [KEY_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]            entry_count;
	} result_t;

	// sequencer next-address control
	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_GOTO,
		JMP_IFT,
		JMP_IFF,
		JMP_DISPATCH
	} jmp_t;

	// condition select
	typedef enum logic [2:0] {
		C_SEARCH,
		C_FULL,
		C_SHIFT,
		C_MORE,
		C_FIND,
		C_RANGE
	} cond_t;

	// datapath operation
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_RD_MID,
		OP_UPD,
		OP_RD_LO,
		OP_FOUND,
		OP_RD_IM1,
		OP_SHIFT,
		OP_PUT,
		OP_RD_IDX,
		OP_RD_VAL,
		OP_SET_BAD,
		OP_CLEAR,
		OP_SET_FULL,
		OP_EMIT
	} op_t;

	typedef struct packed {
		jmp_t            jmp;
		cond_t           cond;
		logic [PC_W-1:0] target;
		op_t             op;
	} uword_t;

	typedef struct packed {
		logic search;
		logic full;
		logic shift;
		logic more;
		logic find;
		logic range;
	} flags_t;

	localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] S_SRCH  = 4'd1;
	localparam logic [PC_W-1:0] S_CMP   = 4'd2;
	localparam logic [PC_W-1:0] S_RDPOS = 4'd3;
	localparam logic [PC_W-1:0] S_FND   = 4'd4;
	localparam logic [PC_W-1:0] S_CHKF  = 4'd5;
	localparam logic [PC_W-1:0] S_SHT   = 4'd6;
	localparam logic [PC_W-1:0] S_SHL   = 4'd7;
	localparam logic [PC_W-1:0] S_PUT   = 4'd8;
	localparam logic [PC_W-1:0] S_RD    = 4'd9;
	localparam logic [PC_W-1:0] S_RDOK  = 4'd10;
	localparam logic [PC_W-1:0] S_RDBAD = 4'd11;
	localparam logic [PC_W-1:0] S_CLR   = 4'd12;
	localparam logic [PC_W-1:0] S_FULL  = 4'd13;
	localparam logic [PC_W-1:0] S_DONE  = 4'd14;

	function automatic uword_t uw(jmp_t j, cond_t c, logic [PC_W-1:0] t, op_t o);
		uword_t w;
		w.jmp    = j;
		w.cond   = c;
		w.target = t;
		w.op     = o;
		return w;
	endfunction

	// microprogram store
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			S_IDLE:  w = uw(JMP_DISPATCH, C_SEARCH, S_IDLE,  OP_LATCH);
			S_SRCH:  w = uw(JMP_IFF,      C_SEARCH, S_RDPOS, OP_RD_MID);
			S_CMP:   w = uw(JMP_GOTO,     C_SEARCH, S_SRCH,  OP_UPD);
			S_RDPOS: w = uw(JMP_NEXT,     C_SEARCH, S_IDLE,  OP_RD_LO);
			S_FND:   w = uw(JMP_IFT,      C_FIND,   S_DONE,  OP_FOUND);
			S_CHKF:  w = uw(JMP_IFT,      C_FULL,   S_FULL,  OP_NOP);
			S_SHT:   w = uw(JMP_IFF,      C_SHIFT,  S_PUT,   OP_RD_IM1);
			S_SHL:   w = uw(JMP_IFT,      C_MORE,   S_SHL,   OP_SHIFT);
			S_PUT:   w = uw(JMP_GOTO,     C_SEARCH, S_DONE,  OP_PUT);
			S_RD:    w = uw(JMP_IFT,      C_RANGE,  S_RDBAD, OP_RD_IDX);
			S_RDOK:  w = uw(JMP_GOTO,     C_SEARCH, S_DONE,  OP_RD_VAL);
			S_RDBAD: w = uw(JMP_GOTO,     C_SEARCH, S_DONE,  OP_SET_BAD);
			S_CLR:   w = uw(JMP_GOTO,     C_SEARCH, S_DONE,  OP_CLEAR);
			S_FULL:  w = uw(JMP_GOTO,     C_SEARCH, S_DONE,  OP_SET_FULL);
			S_DONE:  w = uw(JMP_GOTO,     C_SEARCH, S_IDLE,  OP_EMIT);
			default: w = uw(JMP_GOTO,     C_SEARCH, S_IDLE,  OP_NOP);
		endcase
		return w;
	endfunction

	// entry step for each action
	function automatic logic [PC_W-1:0] dispatch(logic [1:0] action);
		logic [PC_W-1:0] t;
		unique case (action)
			ACT_INSERT, ACT_FIND: t = S_SRCH;
			ACT_READ:             t = S_RD;
			default:              t = S_CLR;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/ssi_ram.sv =====
// ----------------------------------------------------------------------------
// ssi_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ssi_seq.sv =====
// ----------------------------------------------------------------------------
// ssi_seq
// Step counter and microprogram store; issues one control word per cycle.
// ----------------------------------------------------------------------------
`include "sorted_array_insert_search_defines.svh"

module ssi_seq import ssi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  flags_t     flags,
	output uword_t     ctl,
	output logic       busy
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            cond;

	assign ctl  = ucode(pc_q);
	assign busy = (pc_q != S_IDLE);

	always_comb begin
		unique case (ctl.cond)
			C_SEARCH: cond = flags.search;
			C_FULL:   cond = flags.full;
			C_SHIFT:  cond = flags.shift;
			C_MORE:   cond = flags.more;
			C_FIND:   cond = flags.find;
			C_RANGE:  cond = flags.range;
			default:  cond = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctl.jmp)
			JMP_NEXT:     pc_d = pc_q + 1'b1;
			JMP_GOTO:     pc_d = ctl.target;
			JMP_IFT:      pc_d = cond ? ctl.target : pc_q + 1'b1;
			JMP_IFF:      pc_d = cond ? pc_q + 1'b1 : ctl.target;
			JMP_DISPATCH: pc_d = start ? dispatch(action) : pc_q;
			default:      pc_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	`SSI_ASSERT_ALWAYS(a_pc_in_program, clk, arst_n, pc_q <= S_DONE, "step counter left the program")
	`SSI_ASSERT_NEXT(a_start_taken, clk, arst_n, start && !busy, busy, "accepted item did not start")

endmodule

// ===== rtl/ssi_dpath.sv =====
// ----------------------------------------------------------------------------
// ssi_dpath
// Search bounds, shift pointer, count, capacity, key store and result register.
// ----------------------------------------------------------------------------
`include "sorted_array_insert_search_defines.svh"

module ssi_dpath import ssi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  uword_t           ctl,
	input  logic             start,
	input  request_t         request,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	output flags_t           flags,
	output result_t          result,
	output logic             done
);

	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            cap_q;
	logic                        done_q;
	logic [1:0]                  action_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]            idx_q;
	logic [CNT_W-1:0]            lo_q;
	logic [CNT_W-1:0]            hi_q;
	logic [CNT_W-1:0]            mid_q;
	logic [CNT_W-1:0]            i_q;
	logic [1:0]                  status_q;
	logic                        found_q;
	logic signed [KEY_WIDTH-1:0] rval_q;
	result_t                     out_q;

	logic [CNT_W:0]       sum;
	logic [CNT_W-1:0]     mid;
	logic [CNT_W-1:0]     im1;
	logic [CNT_W-1:0]     im2;
	logic [CNT_W-1:0]     cap_eff;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [KEY_WIDTH-1:0] rdata;
	logic                 key_below;

	assign sum       = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = sum[CNT_W:1];
	assign im1       = i_q - 1'b1;
	assign im2       = i_q - CNT_W'(2);
	assign cap_eff   = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign key_below = ($signed(rdata) < key_q);

	assign flags.search = (lo_q < hi_q);
	assign flags.full   = (count_q >= cap_eff);
	assign flags.shift  = (i_q > lo_q);
	assign flags.more   = ({1'b0, i_q} > ({1'b0, lo_q} + (CNT_W+1)'(1)));
	assign flags.find   = (action_q == ACT_FIND);
	assign flags.range  = ({1'b0, idx_q} >= count_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q[AW-1:0];
		ram_wdata = rdata;
		ram_re    = 1'b0;
		ram_raddr = lo_q[AW-1:0];
		unique case (ctl.op)
			OP_RD_MID: begin
				ram_re    = 1'b1;
				ram_raddr = mid[AW-1:0];
			end
			OP_RD_LO: begin
				ram_re    = 1'b1;
				ram_raddr = lo_q[AW-1:0];
			end
			OP_RD_IM1: begin
				ram_re    = 1'b1;
				ram_raddr = im1[AW-1:0];
			end
			// move entry i-1 (read last cycle) up to i, fetch the next one down
			OP_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AW-1:0];
				ram_wdata = rdata;
				ram_re    = 1'b1;
				ram_raddr = im2[AW-1:0];
			end
			OP_RD_IDX: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
			end
			OP_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[AW-1:0];
				ram_wdata = key_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ssi_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(DEPTH);
			done_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (ctl.op == OP_PUT) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.op == OP_CLEAR) begin
				count_q <= '0;
			end
			done_q <= (ctl.op == OP_EMIT);
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LATCH: begin
				if (start) begin
					action_q <= request.action;
					key_q    <= request.key;
					idx_q    <= request.index;
					lo_q     <= '0;
					hi_q     <= count_q;
					i_q      <= count_q;
					status_q <= ST_OK;
					found_q  <= 1'b0;
					rval_q   <= '0;
				end
			end
			OP_RD_MID: mid_q <= mid;
			OP_UPD: begin
				if (key_below) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			OP_FOUND:    found_q  <= (lo_q < count_q) && ($signed(rdata) == key_q);
			OP_SHIFT:    i_q      <= im1;
			OP_RD_VAL:   rval_q   <= $signed(rdata);
			OP_SET_BAD:  status_q <= ST_RANGE;
			OP_SET_FULL: status_q <= ST_FULL;
			OP_EMIT: begin
				out_q.status      <= status_q;
				out_q.position    <= (action_q == ACT_INSERT || action_q == ACT_FIND) ?
					lo_q : '0;
				out_q.found       <= found_q;
				out_q.read_value  <= rval_q;
				out_q.entry_count <= count_q;
			end
			default: begin
			end
		endcase
	end

	assign result = out_q;
	assign done   = done_q;

	`SSI_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`SSI_ASSERT_SAME(a_put_room, clk, arst_n, ctl.op == OP_PUT, count_q < cap_eff, "store into full array")
	`SSI_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "result strobe longer than a cycle")

endmodule

// ===== rtl/sorted_array_insert_search.sv =====
// ----------------------------------------------------------------------------
// sorted_array_insert_search
// Sorted array of signed keys with binary-search insert, find, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start while busy is low; the
//   transfer happens at that clock edge. busy stays high until the item ends.
//   Result channel: done is high for exactly one cycle with result valid.
//   There is no back-pressure, so the receiver must take every result.
//   Config channel: cfg_ready is always high; a transfer on cfg_valid loads
//   the capacity register. Write it only while idle, then issue a clear.
// Operation: insert and find run a binary search over the entries, one RAM
//   read and one compare per probe, then read the entry at the final position
//   and set found; a find ends there. An insert into a full array ends with
//   status full; else it moves the entries at and above the position up one
//   place, one read and one write per entry, and stores the key. All of this
//   goes through the single key RAM, which has a registered read. A new
//   request may go in the cycle done is high.
// Reset: count is zero, capacity is DEPTH; RAM contents are not cleared,
//   since a value read from an entry at or above count is never used.
// ----------------------------------------------------------------------------
module sorted_array_insert_search import ssi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         request,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	uword_t ctl;
	flags_t flags;

	assign cfg_ready = 1'b1;

	ssi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (request.action),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy)
	);

	ssi_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start     (start),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.flags     (flags),
		.result    (result),
		.done      (done)
	);

endmodule
